// File: hdl/bmw_pkg.sv
// bmw_pkg: shared types and codes for the binary morphology window block.
// Holds the transfer payload structs, register indexes, mode codes and
// output queue sizing. No dependencies.
`default_nettype none

package bmw_pkg;

  typedef struct packed {
    logic command;
    logic pixel_in;
  } item_t;

  typedef struct packed {
    logic pixel_out;
    logic frame_end;
  } result_t;

  localparam logic CMD_FLUSH = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd4;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_DILATE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ERODE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HIT_MISS = 2'd2;

  localparam int SIZE_W = 11;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

endpackage

`default_nettype wire

// File: hdl/binary_morphology_window.sv
// binary_morphology_window: streaming binary dilate / erode / hit-or-miss.
// Uses bmw_pkg, bmw_cell, bmw_line_mem and bmw_out_fifo.
//
// Usage:
//   item/item_valid/item_ready carry one pixel or one flush tick per transfer,
//   pixels in raster order. result/result_valid/result_ready return one
//   result pixel per position, in raster order, frame_end on the last one.
//   cfg_write/cfg_index/cfg_data write mode, element, care mask, width and
//   height; a size write restarts the frame. Write only while idle.
// Throughput: one item per cycle. A line store (one read and one write per
//   cycle) feeds a chain of column cells; each advance shifts the window.
// Results: the result for pixel (r,c) is computed in the cycle after the
//   transfer of pixel (r+D,c+D), D = WINDOW-1-(WINDOW-1)/2, and reaches the
//   result port in the cycle after that. After the last pixel, each transfer
//   (flush or pixel) releases one result. For frames of at most D rows the
//   window runs extra fill steps at frame end, with item_ready low.
// Stall: a four-entry result queue absorbs receiver stalls; until the last
//   pixel, item_ready drops only when the queue cannot take another result.
// Reset: registers return to their defaults and all counters clear. The
//   line store needs no clearing pass.
`default_nettype none

module binary_morphology_window #(
  parameter int WINDOW     = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CFG_W = (WINDOW * WINDOW > bmw_pkg::SIZE_W) ?
                         WINDOW * WINDOW : bmw_pkg::SIZE_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  bmw_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output bmw_pkg::result_t              result,
  input  logic                          cfg_write,
  input  logic [bmw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int CTR   = (WINDOW - 1) / 2;
  localparam int AHEAD = WINDOW - 1 - CTR;
  localparam int S     = 2 * AHEAD + 1;
  localparam int LINES = 2 * AHEAD;
  localparam int NB    = WINDOW * WINDOW;
  localparam int FW_W  = $clog2(MAX_WIDTH + 1);
  localparam int FH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int LAG_W = $clog2(AHEAD * MAX_WIDTH + AHEAD + 2);

  // configuration
  logic [bmw_pkg::MODE_W-1:0] mode;
  logic [NB-1:0]              element;
  logic [NB-1:0]              care;
  logic [FW_W-1:0]            frame_w;
  logic [FH_W-1:0]            frame_h;

  // frame control
  logic             all_in;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] v_col;
  logic [COL_W-1:0] v_col_next;
  logic [LAG_W-1:0] lag_left;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             credit;

  // evaluation stage
  logic             st_valid;
  logic [ROW_W-1:0] e_row;
  logic [COL_W-1:0] e_col;
  logic             e_last;

  logic [bmw_pkg::OUT_CNT_W-1:0] fifo_count;

  logic [bmw_pkg::SIZE_W-1:0] size_v;
  logic [FW_W-1:0]            frame_w_cfg;
  logic [FH_W-1:0]            frame_h_cfg;
  logic [FW_W-1:0]            frame_w_next;
  logic [LAG_W-1:0]           lag_load;

  logic room, started, last_pix, last_center;
  logic consume, fill_step, acc, store, drain_acc, advance, emit;
  logic size_write, restart, pix;

  logic [S-1:0] col_new;
  logic [S-1:0] col_q  [S];
  logic [S-1:0] fm     [S];
  logic [S-1:0] row_ok;
  logic [S-1:0] col_ok;
  logic [NB-1:0] win;
  logic          dil;
  logic          border;
  logic          px;
  bmw_pkg::result_t push_data;

  // ---------------------------------------------------------------- control
  always_comb begin
    size_v      = cfg_data[bmw_pkg::SIZE_W-1:0];
    frame_w_cfg = (size_v == '0) ? FW_W'(1) :
                  ((int'(size_v) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : FW_W'(size_v));
    frame_h_cfg = (size_v == '0) ? FH_W'(1) :
                  ((int'(size_v) > MAX_HEIGHT) ? FH_W'(MAX_HEIGHT) : FH_W'(size_v));
    frame_w_next = (cfg_write && cfg_index == bmw_pkg::REG_WIDTH) ? frame_w_cfg : frame_w;
    lag_load     = LAG_W'(AHEAD * int'(frame_w_next) + AHEAD);

    room        = (int'(fifo_count) + int'(st_valid) + 1 <= bmw_pkg::OUT_DEPTH);
    started     = (lag_left == '0);
    last_pix    = (int'(in_row) == int'(frame_h) - 1) && (int'(v_col) == int'(frame_w) - 1);
    last_center = (int'(out_row) == int'(frame_h) - 1) &&
                  (int'(out_col) == int'(frame_w) - 1);

    consume    = all_in && started && credit && room;
    fill_step  = all_in && !started;
    item_ready = all_in ? (!credit || (consume && !last_center)) : room;
    acc        = item_valid && item_ready;
    store      = acc && !all_in && (item.command != bmw_pkg::CMD_FLUSH);
    drain_acc  = acc && all_in;
    advance    = store || fill_step || consume;
    emit       = advance && started;
    size_write = cfg_write &&
                 (cfg_index == bmw_pkg::REG_WIDTH || cfg_index == bmw_pkg::REG_HEIGHT);
    restart    = size_write || (emit && last_center);
    pix        = !all_in && item.pixel_in;

    if (restart) begin
      v_col_next = '0;
    end else if (advance) begin
      v_col_next = (int'(v_col) == int'(frame_w) - 1) ? '0 : v_col + COL_W'(1);
    end else begin
      v_col_next = v_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= bmw_pkg::MODE_DILATE;
      element  <= '1;
      care     <= '1;
      frame_w  <= FW_W'(MAX_WIDTH);
      frame_h  <= FH_W'(MAX_HEIGHT);
      all_in   <= 1'b0;
      in_row   <= '0;
      v_col    <= '0;
      lag_left <= LAG_W'(AHEAD * MAX_WIDTH + AHEAD);
      out_row  <= '0;
      out_col  <= '0;
      credit   <= 1'b0;
      st_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          bmw_pkg::REG_MODE:    mode    <= cfg_data[bmw_pkg::MODE_W-1:0];
          bmw_pkg::REG_ELEMENT: element <= cfg_data[NB-1:0];
          bmw_pkg::REG_CARE:    care    <= cfg_data[NB-1:0];
          bmw_pkg::REG_WIDTH:   frame_w <= frame_w_cfg;
          bmw_pkg::REG_HEIGHT:  frame_h <= frame_h_cfg;
          default: ;
        endcase
      end
      v_col    <= v_col_next;
      st_valid <= emit;
      if (restart) begin
        all_in   <= 1'b0;
        in_row   <= '0;
        lag_left <= lag_load;
        out_row  <= '0;
        out_col  <= '0;
        credit   <= 1'b0;
      end else begin
        if (store) begin
          if (last_pix) begin
            all_in <= 1'b1;
            in_row <= '0;
          end else if (int'(v_col) == int'(frame_w) - 1) begin
            in_row <= in_row + ROW_W'(1);
          end
        end
        if (store && last_pix) begin
          credit <= !emit;
        end else if (drain_acc) begin
          credit <= 1'b1;
        end else if (consume) begin
          credit <= 1'b0;
        end
        if (advance && !started) begin
          lag_left <= lag_left - LAG_W'(1);
        end
        if (emit) begin
          if (int'(out_col) == int'(frame_w) - 1) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      e_row  <= out_row;
      e_col  <= out_col;
      e_last <= last_center;
    end
  end

  // ------------------------------------------------------ line store, cells
  if (LINES > 0) begin : g_lines
    logic [LINES-1:0] rd_data;

    bmw_line_mem #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (LINES)
    ) u_line_mem (
      .clk   (clk),
      .we    (advance),
      .waddr (v_col),
      .wdata (col_new[S-1:1]),
      .raddr (v_col_next),
      .rdata (rd_data)
    );

    assign col_new = {pix, rd_data};
  end else begin : g_no_lines
    assign col_new = pix;
  end

  for (genvar j = 0; j < S; j++) begin : g_cell
    bmw_cell #(
      .S (S)
    ) u_cell (
      .clk        (clk),
      .shift      (advance),
      .col_in     ((j == 0) ? col_new : col_q[(j == 0) ? 0 : j - 1]),
      .row_ok     (row_ok),
      .col_ok     (col_ok[S-1-j]),
      .col_q      (col_q[j]),
      .col_masked (fm[S-1-j])
    );
  end

  // ------------------------------------------------------------- evaluation
  always_comb begin
    for (int i = 0; i < S; i++) begin
      row_ok[i] = (int'(e_row) + i >= AHEAD) &&
                  (int'(e_row) + i < int'(frame_h) + AHEAD);
      col_ok[i] = (int'(e_col) + i >= AHEAD) &&
                  (int'(e_col) + i < int'(frame_w) + AHEAD);
    end
    win = '0;
    dil = 1'b0;
    for (int er = 0; er < WINDOW; er++) begin
      for (int ec = 0; ec < WINDOW; ec++) begin
        win[er*WINDOW+ec] = fm[ec-CTR+AHEAD][er-CTR+AHEAD];
        dil = dil | (element[er*WINDOW+ec] & fm[CTR-ec+AHEAD][CTR-er+AHEAD]);
      end
    end
    border = (int'(e_row) < CTR) || (int'(e_col) < CTR) ||
             (int'(e_row) + AHEAD >= int'(frame_h)) ||
             (int'(e_col) + AHEAD >= int'(frame_w));
    case (mode)
      bmw_pkg::MODE_DILATE:   px = dil;
      bmw_pkg::MODE_ERODE:    px = fm[AHEAD][AHEAD] && ((win & element) == element);
      bmw_pkg::MODE_HIT_MISS: px = !border && (((win ^ element) & care) == '0);
      default:                px = 1'b0;
    endcase
    push_data.pixel_out = px;
    push_data.frame_end = e_last;
  end

  bmw_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (st_valid),
    .push_data    (push_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .count        (fifo_count)
  );

  // ------------------------------------------------------------- assertions
  a_credit_drain: assert property (@(posedge clk) disable iff (rst)
    credit |-> all_in)
    else $error("credit outside drain");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    int'(fifo_count) + int'(st_valid) <= bmw_pkg::OUT_DEPTH)
    else $error("result queue overrun");

  a_drain_transfer: assert property (@(posedge clk) disable iff (rst)
    (acc && all_in && credit) |-> consume)
    else $error("drain transfer without consuming credit");

  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    (all_in && !started) |-> !item_ready)
    else $error("transfer taken during window fill");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (emit && last_center) |=> (!all_in && !credit && out_row == '0 && out_col == '0))
    else $error("counters not cleared after frame end");

endmodule

`default_nettype wire

// File: hdl/bmw_cell.sv
// bmw_cell: one window column of the shifting neighborhood chain.
// Holds a column of pixels, passes it to the next cell on each advance and
// presents it masked by frame validity. Depends on nothing.
`default_nettype none

module bmw_cell #(
  parameter int S = 3
) (
  input  logic         clk,
  input  logic         shift,
  input  logic [S-1:0] col_in,
  input  logic [S-1:0] row_ok,
  input  logic         col_ok,
  output logic [S-1:0] col_q,
  output logic [S-1:0] col_masked
);

  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

  assign col_masked = col_q & row_ok & {S{col_ok}};

endmodule

`default_nettype wire

// File: hdl/bmw_line_mem.sv
// bmw_line_mem: line store, one word per image column.
// Single write port, one registered read port with write-first bypass.
// Depends on nothing.
`default_nettype none

module bmw_line_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/bmw_out_fifo.sv
// bmw_out_fifo: small result queue between the window logic and the
// result channel. Uses bmw_pkg for the result struct and queue sizing.
`default_nettype none

module bmw_out_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  bmw_pkg::result_t             push_data,
  output logic                         result_valid,
  input  logic                         result_ready,
  output bmw_pkg::result_t             result,
  output logic [bmw_pkg::OUT_CNT_W-1:0] count
);

  bmw_pkg::result_t              slots [bmw_pkg::OUT_DEPTH];
  logic [bmw_pkg::OUT_PTR_W-1:0] wr_ptr;
  logic [bmw_pkg::OUT_PTR_W-1:0] rd_ptr;
  logic                          pop;

  assign result_valid = (count != '0);
  assign result       = slots[rd_ptr];
  assign pop          = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bmw_pkg::OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bmw_pkg::OUT_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + bmw_pkg::OUT_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - bmw_pkg::OUT_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: test/tb_binary_morphology_window.sv
// tb_binary_morphology_window: self-checking bench for the streaming binary
// dilate / erode / hit-or-miss block. Needs bmw_pkg and the block's RTL.
// A scoreboard class predicts every result pixel from the accepted items.
import bmw_pkg::*;

class morph_scoreboard;
  localparam int WIN   = 3;
  localparam int CTR   = (WIN - 1) / 2;
  localparam int AHEAD = WIN - 1 - CTR;
  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  localparam int RING  = 2 * WIN * (MAX_W + 1);

  logic [MODE_W-1:0]  mode;
  logic [WIN*WIN-1:0] element;
  logic [WIN*WIN-1:0] care;
  int                 width;
  int                 height;
  bit                 history [RING];
  int                 in_row, in_col, out_row, out_col;
  result_t            pixel_q [$];
  int                 errors, results, ones, frames;

  function new();
    mode    = MODE_DILATE;
    element = '1;
    care    = '1;
    width   = MAX_W;
    height  = MAX_H;
    foreach (history[i]) history[i] = 1'b0;
    restart();
    errors  = 0;
    results = 0;
    ones    = 0;
    frames  = 0;
  endfunction

  function void restart();
    in_row  = 0;
    in_col  = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  function int pending();
    return pixel_q.size();
  endfunction

  function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    int v;
    v = (data == '0) ? 1 : int'(data);
    case (idx)
      REG_MODE: mode = data[MODE_W-1:0];
      REG_ELEMENT: element = data[WIN*WIN-1:0];
      REG_CARE: care = data[WIN*WIN-1:0];
      REG_WIDTH: begin
        width = (v > MAX_W) ? MAX_W : v;
        restart();
      end
      REG_HEIGHT: begin
        height = (v > MAX_H) ? MAX_H : v;
        restart();
      end
      default: ;
    endcase
  endfunction

  function bit pixel_at(int r, int c);
    if (r < 0 || c < 0 || r >= height || c >= width) return 1'b0;
    return history[(r * width + c) % RING];
  endfunction

  function bit morph_at(int r, int c);
    logic [WIN*WIN-1:0] hood;
    bit acc;
    hood = '0;
    acc  = 1'b0;
    for (int er = 0; er < WIN; er++) begin
      for (int ec = 0; ec < WIN; ec++) begin
        hood[er*WIN+ec] = pixel_at(r + er - CTR, c + ec - CTR);
        // dilate uses the reflected element
        if (element[er*WIN+ec]) acc |= pixel_at(r - er + CTR, c - ec + CTR);
      end
    end
    case (mode)
      MODE_DILATE: return acc;
      MODE_ERODE: return pixel_at(r, c) && ((hood & element) == element);
      MODE_HIT_MISS: begin
        if (r < CTR || c < CTR || r + AHEAD >= height || c + AHEAD >= width) return 1'b0;
        return ((hood ^ element) & care) == '0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function void take_item(item_t it);
    int total, n_in, n_out, lag;
    result_t res;
    total = width * height;
    n_in  = in_row * width + in_col;
    n_out = out_row * width + out_col;
    lag   = AHEAD * width + AHEAD;
    if (it.command != CMD_FLUSH && n_in < total) begin
      history[n_in % RING] = it.pixel_in;
      n_in++;
      in_col++;
      if (in_col >= width) begin
        in_col = 0;
        in_row++;
      end
    end
    if (n_out >= total || !(n_in >= n_out + lag + 1 || n_in == total)) return;
    res.pixel_out = morph_at(out_row, out_col);
    res.frame_end = (n_out + 1 == total);
    pixel_q.push_back(res);
    out_col++;
    if (out_col >= width) begin
      out_col = 0;
      out_row++;
    end
    if (res.frame_end) restart();
  endfunction

  task report(string what);
    errors++;
    if (errors <= 40) $display("[%0t] error: %s", $time, what);
  endtask

  task match_result(result_t got);
    result_t want;
    if (pixel_q.size() == 0) begin
      report($sformatf("result %b with nothing outstanding", got));
      return;
    end
    want = pixel_q.pop_front();
    results++;
    if (got.pixel_out === 1'b1) ones++;
    if (want.frame_end) frames++;
    if (got.pixel_out !== want.pixel_out)
      report($sformatf("result %0d: pixel_out %b, want %b", results, got.pixel_out,
                       want.pixel_out));
    if (got.frame_end !== want.frame_end)
      report($sformatf("result %0d: frame_end %b, want %b", results, got.frame_end,
                       want.frame_end));
  endtask

  task flag_leftovers();
    if (pixel_q.size() != 0)
      report($sformatf("%0d result pixels never arrived", pixel_q.size()));
  endtask
endclass

module tb_binary_morphology_window;
  localparam int                CFG_W        = 11;
  localparam int                CLK_HALF     = 10;
  localparam int                RANDOM_ITEMS = 1200;
  localparam logic              CMD_PIXEL    = ~CMD_FLUSH;
  localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;
  localparam logic [8:0]        PLUS_SHAPE   = 9'b010_111_010;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_ready;
  item_t                item         = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  bit              in_calm;
  bit              out_calm;
  int              stim_count;
  morph_scoreboard sb;

  binary_morphology_window u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.match_result(result);
      if (item_valid && item_ready) sb.take_item(item);
    end
  end

  initial begin : result_sink
    int stall;
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      if ($urandom_range(0, 99) == 0) out_calm = ~out_calm;
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(logic cmd, logic pix);
    int    gap;
    item_t nxt;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    nxt.command  = cmd;
    nxt.pixel_in = pix;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= nxt;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic send_bits(logic [15:0] bits, int n);
    for (int i = 0; i < n; i++) send_item(CMD_PIXEL, bits[i]);
  endtask

  // after the last pixel; pixels sent here only push results out
  task automatic drain_frame(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_item(CMD_PIXEL, $urandom_range(0, 1));
      else send_item(CMD_FLUSH, $urandom_range(0, 1));
      stim_count++;
    end
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
    sb.apply_reg(idx, value[SIZE_W-1:0]);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return MODE_SPARE;
    if (r < 4) return MODE_DILATE;
    if (r < 7) return MODE_ERODE;
    return MODE_HIT_MISS;
  endfunction

  function automatic int unsigned pick_bits();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 511;
      2: return $urandom_range(0, 511) & $urandom_range(0, 511);
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  // one frame at the current size; may stop midway with a size restart or
  // change the operation between two pixels
  task automatic run_frame(int density, bit allow_break);
    int total, drain, split, twist;
    total = sb.width * sb.height;
    // results trail the input by one row plus one pixel
    drain = (sb.width + 1 < total - 1) ? sb.width + 1 : total - 1;
    twist = allow_break ? $urandom_range(0, 9) : 9;
    split = $urandom_range(0, total - 1);
    for (int i = 0; i < total; i++) begin
      if (i == split && twist == 0) begin
        wait_idle();
        set_reg($urandom_range(0, 1) ? REG_WIDTH : REG_HEIGHT, $urandom_range(1, 12));
        return;
      end
      if (i == split && twist == 1) begin
        wait_idle();
        set_reg(REG_MODE, pick_mode());
        set_reg(REG_ELEMENT, pick_bits());
      end
      if ($urandom_range(0, 11) == 0) send_item(CMD_FLUSH, $urandom_range(0, 1));
      send_item(CMD_PIXEL, $urandom_range(0, 99) < density);
      stim_count++;
    end
    drain_frame(drain);
    if ($urandom_range(0, 2) == 0) send_item(CMD_FLUSH, $urandom_range(0, 1));
  endtask

  initial begin : stimulus
    int density;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset element and care: dilate on a 2x1 frame
    set_reg(REG_WIDTH, 2);
    set_reg(REG_HEIGHT, 1);
    send_bits(16'b01, 2);
    drain_frame(1);
    wait_idle();

    // erode, zero width acts as one, idle flush, pixel while draining
    set_reg(REG_MODE, MODE_ERODE);
    set_reg(REG_WIDTH, 0);
    set_reg(REG_HEIGHT, 2);
    send_item(CMD_FLUSH, 1'b1);
    send_bits(16'b11, 2);
    send_item(CMD_PIXEL, 1'b0);
    wait_idle();

    // hit-or-miss matching a plus shape at the center
    set_reg(REG_MODE, MODE_HIT_MISS);
    set_reg(REG_ELEMENT, PLUS_SHAPE);
    set_reg(REG_CARE, 511);
    set_reg(REG_WIDTH, 3);
    set_reg(REG_HEIGHT, 3);
    send_bits(16'(PLUS_SHAPE), 9);
    drain_frame(4);
    wait_idle();

    // unused mode code
    set_reg(REG_MODE, MODE_SPARE);
    set_reg(REG_WIDTH, 2);
    set_reg(REG_HEIGHT, 1);
    send_bits(16'b11, 2);
    drain_frame(1);
    wait_idle();

    // oversized writes clamp to the maximum frame size
    set_reg(REG_MODE, MODE_DILATE);
    set_reg(REG_ELEMENT, pick_bits());
    set_reg(REG_WIDTH, 2047);
    set_reg(REG_HEIGHT, 2);
    run_frame(20, 1'b0);
    wait_idle();
    set_reg(REG_MODE, MODE_ERODE);
    set_reg(REG_ELEMENT, 9'b010_010_010);
    set_reg(REG_WIDTH, 1);
    set_reg(REG_HEIGHT, 2047);
    run_frame(80, 1'b0);
    wait_idle();

    stim_count = 0;
    while (stim_count < RANDOM_ITEMS) begin
      in_calm = ($urandom_range(0, 4) == 0);
      if (stim_count == 0 || $urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 19) == 0) begin
          set_reg(REG_WIDTH, $urandom_range(100, 300));
          set_reg(REG_HEIGHT, $urandom_range(1, 3));
        end else begin
          set_reg(REG_WIDTH, $urandom_range(1, 16));
          set_reg(REG_HEIGHT, $urandom_range(1, 10));
        end
      end
      if ($urandom_range(0, 1)) set_reg(REG_MODE, pick_mode());
      if ($urandom_range(0, 1)) set_reg(REG_ELEMENT, pick_bits());
      if ($urandom_range(0, 1)) set_reg(REG_CARE, pick_bits());
      case ($urandom_range(0, 2))
        0: density = 15;
        1: density = 50;
        default: density = 90;
      endcase
      run_frame(density, 1'b1);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    sb.flag_leftovers();
    $display("covered %0d result pixels (%0d set) over %0d complete frames",
             sb.results, sb.ones, sb.frames);
    $display("all mode codes, clamped and minimal sizes, restarts and mid-frame changes");
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: binary_morphology_window.f
hdl/bmw_pkg.sv
hdl/bmw_cell.sv
hdl/bmw_line_mem.sv
hdl/bmw_out_fifo.sv
hdl/binary_morphology_window.sv
test/tb_binary_morphology_window.sv
